FILE: rtl/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg: shared definitions for the RGB LED strip serializer
// Pixel store geometry, operation and status codes, register map and the
// configuration bundle passed from the register block to the datapath.
// ----------------------------------------------------------------------------
package rls_pkg;

   localparam int MAX_PIXELS = 512;
   localparam int PIX_AW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CLR_W      = $clog2(MAX_PIXELS + 1);
   localparam int PIXEL_W    = 24;
   localparam int BITS_PER_PIXEL = 24;

   // operation codes (request tuser)
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_INDEX = 3'd1;
   localparam logic [2:0] ST_BAD_LEN   = 3'd2;
   localparam logic [2:0] ST_DISABLED  = 3'd3;
   localparam logic [2:0] ST_BUSY      = 3'd4;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_PERIOD    = 3'd0;
   localparam logic [2:0] REG_ZERO_HIGH = 3'd1;
   localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
   localparam logic [2:0] REG_RST_SLOTS = 3'd3;
   localparam logic [2:0] REG_ENABLE    = 3'd4;

   localparam logic [15:0] PERIOD_RST    = 16'd105;
   localparam logic [15:0] ZERO_HIGH_RST = 16'd33;
   localparam logic [15:0] ONE_HIGH_RST  = 16'd67;
   localparam logic [9:0]  RST_SLOTS_RST = 10'd240;

   typedef struct packed {
      logic [15:0] bit_period_ticks;
      logic [15:0] zero_pulse_len;
      logic [15:0] one_pulse_len;
      logic [9:0]  reset_slots;
      logic        channel_enabled;
   } cfg_type;

endpackage

FILE: rtl/rls_ram.sv
// ----------------------------------------------------------------------------
// rls_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module rls_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/rls_csr.sv
// ----------------------------------------------------------------------------
// rls_csr: configuration registers of the serializer
// APB-style write and read access to the five timing and enable registers.
// ----------------------------------------------------------------------------
module rls_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [4:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready,
   output rls_pkg::cfg_type cfg
);

   rls_pkg::cfg_type cfg_ff;
   rls_pkg::cfg_type cfg_in;
   logic [2:0]       reg_idx;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rls_pkg::REG_PERIOD:    cfg_in.bit_period_ticks = csr_pwdata[15:0];
            rls_pkg::REG_ZERO_HIGH: cfg_in.zero_pulse_len   = csr_pwdata[15:0];
            rls_pkg::REG_ONE_HIGH:  cfg_in.one_pulse_len    = csr_pwdata[15:0];
            rls_pkg::REG_RST_SLOTS: cfg_in.reset_slots      = csr_pwdata[9:0];
            rls_pkg::REG_ENABLE:    cfg_in.channel_enabled  = csr_pwdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rls_pkg::REG_PERIOD:    csr_prdata = {16'd0, cfg_ff.bit_period_ticks};
         rls_pkg::REG_ZERO_HIGH: csr_prdata = {16'd0, cfg_ff.zero_pulse_len};
         rls_pkg::REG_ONE_HIGH:  csr_prdata = {16'd0, cfg_ff.one_pulse_len};
         rls_pkg::REG_RST_SLOTS: csr_prdata = {22'd0, cfg_ff.reset_slots};
         rls_pkg::REG_ENABLE:    csr_prdata = {31'd0, cfg_ff.channel_enabled};
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period_ticks <= rls_pkg::PERIOD_RST;
         cfg_ff.zero_pulse_len   <= rls_pkg::ZERO_HIGH_RST;
         cfg_ff.one_pulse_len    <= rls_pkg::ONE_HIGH_RST;
         cfg_ff.reset_slots      <= rls_pkg::RST_SLOTS_RST;
         cfg_ff.channel_enabled  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/rgb_led_strip_serializer_top.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_serializer_top: one-wire RGB LED strip serializer
// Each accepted request gets its response transaction in the following cycle.
// Throughput: one request per cycle while the response stream is not stalled;
// the pixel store read for the next pixel is issued on the tick that closes a
// pixel, so ticks may arrive every cycle. Reset: synchronous, active high;
// then a clearing pass zeroes the pixel store, while no request is accepted.
// ----------------------------------------------------------------------------
module rgb_led_strip_serializer_top (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [9:0] pixel_index, [17:10] red, [25:18] green, [33:26] blue,
   // [43:34] frame_length, [47:44] zero
   input  logic [47:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] line_level, [1] busy_res, [4:2] status, [7:5] zero
   output logic [7:0]  rsp_tdata,
   // frame_done: tick that ends the reset gap
   output logic        rsp_tlast,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_GAP  = 2'd2;

   localparam int AW = rls_pkg::PIX_AW;
   localparam int CW = rls_pkg::CLR_W;

   rls_pkg::cfg_type cfg;

   // request fields
   logic [1:0]  op;
   logic [9:0]  pixel_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [9:0]  frame_length;
   logic        accept;

   // serializer state
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] shift_ff, shift_in;
   logic [9:0]  pix_pos_ff, pix_pos_in;
   logic [4:0]  bit_pos_ff, bit_pos_in;
   logic [15:0] tick_ff, tick_in;
   logic [9:0]  gap_cnt_ff, gap_cnt_in;
   logic [9:0]  length_ff, length_in;
   logic        load_pend_ff, load_pend_in;

   // clearing pass
   logic [CW-1:0] clr_cnt_ff;
   logic          clear_done;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // pixel store ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [23:0]   ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [23:0]   ram_rdata;

   // datapath helpers
   logic [23:0] cur_word;
   logic [15:0] period;
   logic [15:0] high_sel;
   logic [15:0] high;
   logic [15:0] tick_inc;
   logic [4:0]  bit_inc;
   logic [9:0]  pix_inc;
   logic [9:0]  gap_inc;
   logic [9:0]  slots;
   logic        slot_end;
   logic        write_ok;
   logic        start_ok;
   logic        line;
   logic        busy;
   logic        done;
   logic [2:0]  status;

   rls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Unpack the request transaction.
   assign op           = req_tuser;
   assign pixel_index  = req_tdata[9:0];
   assign red          = req_tdata[17:10];
   assign green        = req_tdata[25:18];
   assign blue         = req_tdata[33:26];
   assign frame_length = req_tdata[43:34];

   // Hold requests off during the clearing pass and while a response waits
   // that cannot leave this cycle.
   assign clear_done = (clr_cnt_ff == CW'(rls_pkg::MAX_PIXELS));
   assign req_tready = clear_done & (~rsp_valid_ff | rsp_tready);
   assign accept     = req_tvalid & req_tready;

   // A freshly read pixel sits in the RAM output register until the first
   // tick shifts it into the local shift register.
   assign cur_word = load_pend_ff ? ram_rdata : shift_ff;

   // Bit timing: period floors at two ticks, high time clamps below period.
   assign period   = (cfg.bit_period_ticks < 16'd2) ? 16'd2 : cfg.bit_period_ticks;
   assign high_sel = cur_word[23] ? cfg.one_pulse_len : cfg.zero_pulse_len;
   assign high     = (high_sel >= period) ? (period - 16'd1) : high_sel;
   assign tick_inc = tick_ff + 16'd1;
   assign slot_end = (tick_inc >= period);
   assign bit_inc  = bit_pos_ff + 5'd1;
   assign pix_inc  = pix_pos_ff + 10'd1;
   assign gap_inc  = gap_cnt_ff + 10'd1;
   assign slots    = (cfg.reset_slots == 10'd0) ? 10'd1 : cfg.reset_slots;

   assign write_ok = accept & (op == rls_pkg::OP_WRITE)
                   & (pixel_index < 10'(rls_pkg::MAX_PIXELS)) & (phase_ff == PH_IDLE);
   assign start_ok = accept & (op == rls_pkg::OP_START)
                   & (frame_length != 10'd0) & (frame_length <= 10'(rls_pkg::MAX_PIXELS))
                   & cfg.channel_enabled & (phase_ff == PH_IDLE);

   always_comb begin
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      pix_pos_in   = pix_pos_ff;
      bit_pos_in   = bit_pos_ff;
      tick_in      = tick_ff;
      gap_cnt_in   = gap_cnt_ff;
      length_in    = length_ff;
      load_pend_in = load_pend_ff;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      line         = 1'b0;
      busy         = 1'b0;
      done         = 1'b0;
      status       = rls_pkg::ST_OK;

      if (accept) begin
         case (op)
            rls_pkg::OP_WRITE: begin
               if (pixel_index >= 10'(rls_pkg::MAX_PIXELS)) begin
                  status = rls_pkg::ST_BAD_INDEX;
               end else if (phase_ff != PH_IDLE) begin
                  status = rls_pkg::ST_BUSY;
               end
               busy = (phase_ff != PH_IDLE);
            end
            rls_pkg::OP_START: begin
               if (frame_length == 10'd0
                   || frame_length > 10'(rls_pkg::MAX_PIXELS)) begin
                  status = rls_pkg::ST_BAD_LEN;
               end else if (!cfg.channel_enabled) begin
                  status = rls_pkg::ST_DISABLED;
               end else if (phase_ff != PH_IDLE) begin
                  status = rls_pkg::ST_BUSY;
               end
               if (start_ok) begin
                  // Latch the frame and fetch pixel zero.
                  length_in    = frame_length;
                  pix_pos_in   = 10'd0;
                  bit_pos_in   = 5'd0;
                  tick_in      = 16'd0;
                  gap_cnt_in   = 10'd0;
                  ram_re       = 1'b1;
                  ram_raddr    = '0;
                  load_pend_in = 1'b1;
                  phase_in     = PH_DATA;
               end
               busy = start_ok | (phase_ff != PH_IDLE);
            end
            rls_pkg::OP_TICK: begin
               if (phase_ff == PH_DATA) begin
                  busy         = 1'b1;
                  line         = (tick_ff < high);
                  tick_in      = tick_inc;
                  shift_in     = cur_word;
                  load_pend_in = 1'b0;
                  if (slot_end) begin
                     tick_in    = 16'd0;
                     shift_in   = {cur_word[22:0], 1'b0};
                     bit_pos_in = bit_inc;
                     if (bit_inc >= 5'(rls_pkg::BITS_PER_PIXEL)) begin
                        // Pixel done: move to the gap or prefetch the next one.
                        bit_pos_in = 5'd0;
                        pix_pos_in = pix_inc;
                        if (pix_inc >= length_ff) begin
                           phase_in   = PH_GAP;
                           gap_cnt_in = 10'd0;
                        end else begin
                           ram_re       = 1'b1;
                           ram_raddr    = pix_inc[AW-1:0];
                           load_pend_in = 1'b1;
                        end
                     end
                  end
               end else if (phase_ff == PH_GAP) begin
                  busy    = 1'b1;
                  tick_in = tick_inc;
                  if (slot_end) begin
                     tick_in    = 16'd0;
                     gap_cnt_in = gap_inc;
                     if (gap_inc >= slots) begin
                        phase_in   = PH_IDLE;
                        gap_cnt_in = 10'd0;
                        done       = 1'b1;
                     end
                  end
               end
            end
            default: begin
               busy = (phase_ff != PH_IDLE);
            end
         endcase
      end
   end

   // Pixel store writes: zero fill during the clearing pass, else accepted
   // writes in green-red-blue order.
   assign ram_we    = ~clear_done | write_ok;
   assign ram_waddr = clear_done ? pixel_index[AW-1:0] : clr_cnt_ff[AW-1:0];
   assign ram_wdata = clear_done ? {green, red, blue} : 24'd0;

   rls_ram #(
      .WIDTH (rls_pkg::PIXEL_W),
      .DEPTH (rls_pkg::MAX_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_data_in = {3'd0, status, busy, line};
   assign rsp_last_in = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= 24'd0;
         pix_pos_ff   <= 10'd0;
         bit_pos_ff   <= 5'd0;
         tick_ff      <= 16'd0;
         gap_cnt_ff   <= 10'd0;
         length_ff    <= 10'd0;
         load_pend_ff <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         pix_pos_ff   <= pix_pos_in;
         bit_pos_ff   <= bit_pos_in;
         tick_ff      <= tick_in;
         gap_cnt_ff   <= gap_cnt_in;
         length_ff    <= length_in;
         load_pend_ff <= load_pend_in;
         if (!clear_done) begin
            clr_cnt_ff <= clr_cnt_ff + CW'(1);
         end
         // Advance the response register on accept, drop it once taken.
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // No request transaction may slip in during the clearing pass.
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> !req_tready)
      else $error("request accepted during clearing pass");

   // A pixel write after the clearing pass only lands while idle.
   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      (ram_we && clear_done) |-> (phase_ff == PH_IDLE))
      else $error("pixel store written during a frame");

   // A pending pixel load only exists in the data phase.
   a_pend_in_data: assert property (@(posedge clock) disable iff (reset)
      load_pend_ff |-> (phase_ff == PH_DATA))
      else $error("pixel load pending outside data phase");

   // A frame-done response always reports the tick as part of the frame.
   a_done_is_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_data_ff[1])
      else $error("frame_done without busy");
`endif

endmodule
